/* src/tlf_pkg.sv */
// shared types, character codes and helpers for the text line folder
// no dependencies; used by tlf_cell, tlf_ctrl and text_line_folder_top

package tlf_pkg;

  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_NEWLINE = 8'd10;

  // per-cell control: load the incoming byte, or take the right neighbor's byte
  typedef struct packed {
    logic shift;
    logic load;
  } tlf_cell_ctl_t;

  function automatic logic is_blank(input logic [7:0] b);
    is_blank = (b == CH_SPACE) || (b == CH_TAB);
  endfunction

endpackage

/* src/tlf_cell.sv */
// one byte cell of the line buffer chain
// depends on tlf_pkg (cell control struct)

module tlf_cell (
  input  logic                  clk,
  input  tlf_pkg::tlf_cell_ctl_t ctl,
  input  logic [7:0]            shift_in,
  input  logic [7:0]            din,
  output logic [7:0]            q
);

  // load and shift never coincide: loads happen only while the sequencer is idle
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      q <= din;
    end else if (ctl.shift) begin
      q <= shift_in;
    end
  end

endmodule

/* src/tlf_ctrl.sv */
// sequencer of the text line folder: intake, fold point tracking, output register
// depends on tlf_pkg (character codes, is_blank, cell control struct)

module tlf_ctrl #(
  parameter int FOLD_WIDTH = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,
  input  logic                           s_tlast,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [7:0]                     m_tdata,
  output logic                           m_tlast,
  input  logic [7:0]                     head,
  output tlf_pkg::tlf_cell_ctl_t         row_ctl,
  output logic [$clog2(FOLD_WIDTH+1)-1:0] wr_idx
);

  localparam int DEPTH = FOLD_WIDTH + 1;
  localparam int IW    = $clog2(FOLD_WIDTH + 1);
  localparam int CW    = $clog2(FOLD_WIDTH + 2);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FOLD  = 3'd1;
  localparam logic [2:0] ST_NL    = 3'd2;
  localparam logic [2:0] ST_SKIP  = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;

  logic [2:0]    state;
  logic [CW-1:0] fill;
  logic [CW-1:0] last_nb_end;
  logic [CW-1:0] fold_p;
  logic [CW-1:0] rem;
  logic          skipping;
  logic          drain_after;

  logic          accept;
  logic          in_blank;
  logic          in_nl;
  logic          take_byte;
  logic [CW-1:0] fill_inc;
  logic [CW-1:0] fold_p_next;
  logic          out_free;
  logic          emit_go;
  logic          skip_go;

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign in_blank  = tlf_pkg::is_blank(s_tdata);
  assign in_nl     = (s_tdata == tlf_pkg::CH_NEWLINE);
  assign take_byte = accept && !s_tlast && !(skipping && in_blank);
  assign fill_inc  = fill + CW'(1);
  assign out_free  = !m_tvalid || m_tready;
  assign emit_go   = out_free && ((state == ST_FOLD) || (state == ST_DRAIN));
  assign skip_go   = (state == ST_SKIP) && (fill != '0) && tlf_pkg::is_blank(head);

  assign row_ctl.load  = take_byte;
  assign row_ctl.shift = emit_go || skip_go;
  assign wr_idx        = fill[IW-1:0];

  // a blank past index 0 moves the fold point behind the last non-blank before it
  always_comb begin
    fold_p_next = fold_p;
    if (in_blank && (fill != '0)) begin
      fold_p_next = (last_nb_end == '0) ? CW'(FOLD_WIDTH) : last_nb_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      fill        <= '0;
      last_nb_end <= '0;
      fold_p      <= CW'(FOLD_WIDTH);
      rem         <= '0;
      skipping    <= 1'b0;
      drain_after <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept && s_tlast) begin
            skipping    <= 1'b0;
            last_nb_end <= '0;
            fold_p      <= CW'(FOLD_WIDTH);
            if (fill != '0) begin
              state <= ST_DRAIN;
            end
          end else if (take_byte) begin
            skipping    <= 1'b0;
            fill        <= fill_inc;
            fold_p      <= fold_p_next;
            drain_after <= in_nl;
            if (!in_blank) begin
              last_nb_end <= fill_inc;
            end
            if (fill_inc == CW'(DEPTH)) begin
              state <= ST_FOLD;
              rem   <= fold_p_next;
            end else if (in_nl) begin
              state <= ST_DRAIN;
            end
          end
        end
        ST_FOLD: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            fill     <= fill - CW'(1);
            rem      <= rem - CW'(1);
            if (rem == CW'(1)) begin
              state <= ST_NL;
            end
          end
        end
        ST_NL: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          if (skip_go) begin
            fill <= fill - CW'(1);
            if (fill == CW'(1)) begin
              // whole tail was blank: keep dropping blanks that follow
              skipping    <= 1'b1;
              last_nb_end <= '0;
              fold_p      <= CW'(FOLD_WIDTH);
              state       <= ST_IDLE;
            end
          end else begin
            // kept tail holds no blanks
            last_nb_end <= fill;
            fold_p      <= CW'(FOLD_WIDTH);
            state       <= (drain_after && (fill != '0)) ? ST_DRAIN : ST_IDLE;
          end
        end
        ST_DRAIN: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            fill     <= fill - CW'(1);
            if (fill == CW'(1)) begin
              last_nb_end <= '0;
              fold_p      <= CW'(FOLD_WIDTH);
              state       <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (emit_go) begin
      m_tdata <= head;
      m_tlast <= (state == ST_DRAIN) && (fill == CW'(1));
    end else if ((state == ST_NL) && out_free) begin
      m_tdata <= tlf_pkg::CH_NEWLINE;
      m_tlast <= !drain_after;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(DEPTH))
    else $error("line buffer count out of range");

  a_emit_waits: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_FOLD || state == ST_DRAIN) && !out_free) |=> $stable(fill))
    else $error("buffer shifted while output register was held");

  a_skip_drops: assert property (@(posedge clk) disable iff (rst)
    skip_go |=> (fill == $past(fill) - CW'(1)))
    else $error("blank after fold not dropped");

  a_fold_newline: assert property (@(posedge clk) disable iff (rst)
    (state == ST_NL && out_free) |=> (m_tvalid && m_tdata == tlf_pkg::CH_NEWLINE))
    else $error("fold newline not presented");
`endif

endmodule

/* src/text_line_folder_top.sv */
// top level of the text line folder: chain of byte cells plus sequencer
// depends on tlf_pkg, tlf_cell and tlf_ctrl

// Folds text lines longer than FOLD_WIDTH bytes at the last blank (space or
// tab). Bytes arrive on the slave stream, one per request, with s_tlast
// marking end of input (the data byte of that request is ignored and the
// buffered line is sent out as it stands). The line is held in a row of
// FOLD_WIDTH+1 byte cells; buffered bytes always leave from cell 0 while the
// row shifts one place toward it per cycle, unless the output register is
// held. When the row fills up, the bytes before the fold point go out
// followed by a newline, blanks at the fold are dropped, and, if the whole
// tail was blank, so are blanks that arrive next, until a non-blank byte. A
// newline byte sends the buffered line, newline included. m_tlast marks the
// final byte that a request caused. While a request sends out bytes,
// s_tready stays low for each byte through the output register, for each
// blank dropped after a fold and for the check of the kept tail when a fold
// keeps one; m_tready low while a result waits holds it low longer. The
// single output shift path out of cell 0 is what keeps s_tready low so long.
// The output register lets the next request in while the last result still
// waits on m_tready.

module text_line_folder_top #(
  parameter int FOLD_WIDTH = 10
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // in_byte [7:0]
  input  logic       s_tlast,   // flush
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // out_byte [7:0]
  output logic       m_tlast    // last byte of this request
);

  localparam int DEPTH = FOLD_WIDTH + 1;
  localparam int IW    = $clog2(FOLD_WIDTH + 1);

  tlf_pkg::tlf_cell_ctl_t row_ctl;
  logic [IW-1:0]          wr_idx;
  logic [7:0]             cell_q [DEPTH];

  tlf_ctrl #(
    .FOLD_WIDTH(FOLD_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .head     (cell_q[0]),
    .row_ctl  (row_ctl),
    .wr_idx   (wr_idx)
  );

  // the row: each cell takes the input byte when addressed, or its right neighbor on shift
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    tlf_pkg::tlf_cell_ctl_t cell_ctl;
    logic [7:0]             shift_in;

    assign cell_ctl.shift = row_ctl.shift;
    assign cell_ctl.load  = row_ctl.load && (wr_idx == IW'(i));

    if (i == DEPTH - 1) begin : g_end
      // far end refills with its own byte; that slot is past the count anyway
      assign shift_in = cell_q[i];
    end else begin : g_mid
      assign shift_in = cell_q[i+1];
    end

    tlf_cell u_cell (
      .clk      (clk),
      .ctl      (cell_ctl),
      .shift_in (shift_in),
      .din      (s_tdata),
      .q        (cell_q[i])
    );
  end

endmodule
